/* rtl/pale_pkg.sv */
package pale_pkg;

    localparam int CMD_W   = 4;
    localparam int ELEM_W  = 32;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 4'd0,
        CMD_INS_FIRST = 4'd1,
        CMD_INS_AT    = 4'd2,
        CMD_INS_LAST  = 4'd3,
        CMD_DEL_FIRST = 4'd4,
        CMD_DEL_AT    = 4'd5,
        CMD_DEL_LAST  = 4'd6,
        CMD_SEARCH    = 4'd7,
        CMD_GET       = 4'd8,
        CMD_SET       = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_LOAD  = 2'd3
    } t_cell_sel;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ELEM_W-1:0] element;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [ELEM_W-1:0] read_value;
        logic              found;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
        logic              is_full;
        t_status           status;
    } t_out_item;

endpackage

/* rtl/pale_cell.sv */
module pale_cell import pale_pkg::*; #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_take,
    input  t_cell_sel             i_sel,
    input  logic [ELEM_WIDTH-1:0] i_elem,
    input  logic [ELEM_WIDTH-1:0] i_left,
    input  logic [ELEM_WIDTH-1:0] i_right,
    input  logic                  i_live,
    output logic [ELEM_WIDTH-1:0] o_entry,
    output logic                  o_match
);

    logic [ELEM_WIDTH-1:0] r_entry;
    logic [ELEM_WIDTH-1:0] n_entry;
    logic                  r_match;

    always_comb begin
        unique case (i_sel)
            SEL_LEFT:  n_entry = i_left;
            SEL_RIGHT: n_entry = i_right;
            SEL_LOAD:  n_entry = i_elem;
            default:   n_entry = r_entry;
        endcase
    end

    // compare uses the entry as it stood before this item
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_take) begin
            r_match <= i_live && (r_entry == i_elem);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

/* rtl/packed_array_list_engine_unit.sv */
// channel | direction | valid        | stall        | payload
// --------+-----------+--------------+--------------+------------------------
// in      | input     | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
// out     | output    | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//
// items enter only while stage two is empty; the accepting cycle shifts, loads and
// compares in the cells, then stage two ors the match bits into the output register
// a result waits in the output register while i_out_stall is high; the next item is
// taken meanwhile and its result waits in the second stage, which holds o_in_stall
// reset clears the entry count and both stages; entries are undefined until written
module packed_array_list_engine_unit import pale_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic                  take;
    logic                  move;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_pend;
    logic                  r_out_valid;
    logic [ELEM_W-1:0]     r_p_rd;
    t_status               r_p_st;
    t_out_item             r_out_item;
    t_status               st;
    logic [ELEM_W-1:0]     rd;
    logic                  do_ins;
    logic                  do_del;
    logic                  do_set;
    logic                  is_search;
    logic [XW-1:0]         at_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         pos_x;
    logic [ELEM_WIDTH-1:0] elem;
    logic [ELEM_WIDTH-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]      w_match;

    assign take  = i_in_valid && !r_pend;
    assign move  = r_pend && (!r_out_valid || !i_out_stall);
    assign cnt_x = XW'(r_count);
    assign pos_x = XW'(i_in_item.position);
    assign elem  = ELEM_WIDTH'(i_in_item.element);

    always_comb begin
        n_count   = r_count;
        st        = ST_OK;
        rd        = '0;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        do_set    = 1'b0;
        is_search = 1'b0;
        at_x      = '0;
        unique case (t_cmd'(i_in_item.cmd))
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST: begin
                if (t_cmd'(i_in_item.cmd) == CMD_INS_AT) begin
                    at_x = pos_x;
                end else if (t_cmd'(i_in_item.cmd) == CMD_INS_LAST) begin
                    at_x = cnt_x;
                end
                priority if (r_count == CW'(DEPTH)) begin
                    st = ST_FULL;
                end else if (at_x > cnt_x) begin
                    st = ST_BADIDX;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DEL_FIRST, CMD_DEL_AT, CMD_DEL_LAST: begin
                if (t_cmd'(i_in_item.cmd) == CMD_DEL_AT) begin
                    at_x = pos_x;
                end else if (t_cmd'(i_in_item.cmd) == CMD_DEL_LAST) begin
                    at_x = cnt_x - XW'(1);
                end
                priority if (r_count == '0) begin
                    st = ST_EMPTY;
                end else if (at_x >= cnt_x) begin
                    st = ST_BADIDX;
                end else begin
                    do_del  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            CMD_SEARCH: begin
                is_search = 1'b1;
            end
            CMD_GET: begin
                if (pos_x < cnt_x) begin
                    rd = ELEM_W'(w_entry[IW'(i_in_item.position)]);
                end else begin
                    st = ST_BADIDX;
                end
            end
            CMD_SET: begin
                if (pos_x < cnt_x) begin
                    do_set = 1'b1;
                end else begin
                    st = ST_BADIDX;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [XW-1:0] KX = XW'(k);
        t_cell_sel             sel;
        logic                  live;
        logic [ELEM_WIDTH-1:0] left;
        logic [ELEM_WIDTH-1:0] right;

        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = w_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = w_entry[k+1];
        end

        always_comb begin
            sel = SEL_HOLD;
            if (take) begin
                priority if (do_ins) begin
                    if (KX == at_x) begin
                        sel = SEL_LOAD;
                    end else if (KX > at_x && KX <= cnt_x) begin
                        sel = SEL_LEFT;
                    end
                end else if (do_del) begin
                    if (KX >= at_x && (KX + XW'(1)) < cnt_x) begin
                        sel = SEL_RIGHT;
                    end
                end else if (do_set) begin
                    if (KX == pos_x) begin
                        sel = SEL_LOAD;
                    end
                end
            end
        end

        assign live = is_search && (KX < cnt_x);

        pale_cell #(
            .ELEM_WIDTH(ELEM_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_take  (take),
            .i_sel   (sel),
            .i_elem  (elem),
            .i_left  (left),
            .i_right (right),
            .i_live  (live),
            .o_entry (w_entry[k]),
            .o_match (w_match[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_count <= n_count;
            end
            if (take) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_p_rd <= rd;
            r_p_st <= st;
        end
        if (move) begin
            r_out_item.read_value  <= r_p_rd;
            r_out_item.found       <= |w_match;
            r_out_item.entry_count <= CNT_W'(r_count);
            r_out_item.is_empty    <= (r_count == '0);
            r_out_item.is_full     <= (r_count == CW'(DEPTH));
            r_out_item.status      <= r_p_st;
        end
    end

    assign o_in_stall  = r_pend;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge i_clk)
        (i_rst_n && !take) |=> $stable(r_count))
        else $error("entry count changed without an item");

    a_take_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_pend)
        else $error("accepted item not held in second stage");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.found) |-> (o_out_item.status == ST_OK))
        else $error("search hit with bad status");

endmodule

/* verif/packed_array_list_engine_unit_tb.sv */
`timescale 1ns / 100ps

module packed_array_list_engine_unit_tb;
    import pale_pkg::*;

    localparam int LIST_DEPTH       = 16;
    localparam int LONG_HOLD_CYCLES = 40;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    logic [ELEM_W-1:0] shadow_words [LIST_DEPTH];
    int                shadow_len = 0;
    t_out_item         pending_results [$];

    bit idle_on = 1'b1;
    bit hold_out_req = 1'b0;
    int hold_cycle;
    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    packed_array_list_engine_unit #(
        .DEPTH      (LIST_DEPTH),
        .ELEM_WIDTH (ELEM_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // list behavior: updates the shadow list and gives the status item
    function automatic t_out_item apply_list_cmd(t_in_item it);
        t_out_item r;
        int at;
        int k;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_CLEAR: begin
                shadow_len = 0;
            end
            CMD_INS_FIRST, CMD_INS_AT, CMD_INS_LAST: begin
                at = (it.cmd == CMD_INS_FIRST) ? 0 :
                     (it.cmd == CMD_INS_LAST) ? shadow_len : int'(it.position);
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (at > shadow_len) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (k = shadow_len; k > at; k--) shadow_words[k] = shadow_words[k-1];
                    shadow_words[at] = it.element;
                    shadow_len++;
                end
            end
            CMD_DEL_FIRST, CMD_DEL_AT, CMD_DEL_LAST: begin
                at = (it.cmd == CMD_DEL_FIRST) ? 0 :
                     (it.cmd == CMD_DEL_LAST) ? shadow_len - 1 : int'(it.position);
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (at >= shadow_len) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (k = at; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            CMD_SEARCH: begin
                for (k = 0; k < shadow_len; k++) begin
                    if (shadow_words[k] == it.element) r.found = 1'b1;
                end
            end
            CMD_GET: begin
                if (int'(it.position) < shadow_len) r.read_value = shadow_words[it.position];
                else r.status = ST_BADIDX;
            end
            CMD_SET: begin
                if (int'(it.position) < shadow_len) shadow_words[it.position] = it.element;
                else r.status = ST_BADIDX;
            end
            default: begin
            end
        endcase
        r.entry_count = CNT_W'(shadow_len);
        r.is_empty    = (shadow_len == 0);
        r.is_full     = (shadow_len == LIST_DEPTH);
        return r;
    endfunction

    function automatic t_in_item list_cmd(logic [CMD_W-1:0] c, logic [ELEM_W-1:0] e,
                                          logic [POS_W-1:0] p);
        t_in_item it;
        it.cmd      = c;
        it.element  = e;
        it.position = p;
        return it;
    endfunction

    // random command biased toward inserts by ins_pct, deletes take 85 - ins_pct
    function automatic t_in_item random_list_cmd(int ins_pct);
        t_in_item it;
        int roll;
        int pos_cap;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            case ($urandom_range(0, 2))
                0: it.cmd = CMD_INS_FIRST;
                1: it.cmd = CMD_INS_AT;
                default: it.cmd = CMD_INS_LAST;
            endcase
        end else if (roll < 85) begin
            case ($urandom_range(0, 2))
                0: it.cmd = CMD_DEL_FIRST;
                1: it.cmd = CMD_DEL_AT;
                default: it.cmd = CMD_DEL_LAST;
            endcase
        end else if (roll < 97) begin
            case ($urandom_range(0, 2))
                0: it.cmd = CMD_SEARCH;
                1: it.cmd = CMD_GET;
                default: it.cmd = CMD_SET;
            endcase
        end else if (roll < 98) begin
            it.cmd = CMD_CLEAR;
        end else begin
            it.cmd = CMD_W'($urandom_range(0, 15));
        end
        pos_cap = (shadow_len > 15) ? 15 : shadow_len;
        if ($urandom_range(0, 4) == 0) it.position = POS_W'($urandom_range(0, 15));
        else it.position = POS_W'($urandom_range(0, pos_cap));
        roll = $urandom_range(0, 99);
        if (shadow_len > 0 && roll < 30) it.element = shadow_words[$urandom_range(0, shadow_len - 1)];
        else if (roll < 50) it.element = $urandom_range(0, 7);
        else it.element = $urandom;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_list_cmd(it));
        items_sent++;
    endtask

    task automatic flag_field(string field_name, logic [ELEM_W-1:0] want_v,
                              logic [ELEM_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, field_name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, expected none actual %0h", $time, o_out_item);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                flag_field("read_value", want.read_value, o_out_item.read_value);
                flag_field("found", ELEM_W'(want.found), ELEM_W'(o_out_item.found));
                flag_field("entry_count", ELEM_W'(want.entry_count),
                           ELEM_W'(o_out_item.entry_count));
                flag_field("is_empty", ELEM_W'(want.is_empty), ELEM_W'(o_out_item.is_empty));
                flag_field("is_full", ELEM_W'(want.is_full), ELEM_W'(o_out_item.is_full));
                flag_field("status", ELEM_W'(want.status), ELEM_W'(o_out_item.status));
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // receiver side: short random stalls, or one long hold when asked
    always begin
        @(posedge i_clk);
        if (hold_out_req) begin
            i_out_stall <= 1'b1;
            for (hold_cycle = 0; hold_cycle < LONG_HOLD_CYCLES; hold_cycle++) @(posedge i_clk);
            i_out_stall <= 1'b0;
            hold_out_req = 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic test_empty_list;
        send_item(list_cmd(CMD_DEL_FIRST, '0, '0));
        send_item(list_cmd(CMD_DEL_AT, '0, '0));
        send_item(list_cmd(CMD_DEL_LAST, '0, '1));
        send_item(list_cmd(CMD_SEARCH, '0, '0));
        send_item(list_cmd(CMD_GET, '0, '0));
        send_item(list_cmd(CMD_SET, '1, '0));
        send_item(list_cmd('1, '1, '1));
        send_item(list_cmd(CMD_INS_AT, 32'h0000_0001, 4'd1));
    endtask

    task automatic test_index_ops;
        send_item(list_cmd(CMD_INS_LAST, 32'hFFFF_FFFF, '0));
        send_item(list_cmd(CMD_INS_FIRST, 32'h0000_0000, '1));
        send_item(list_cmd(CMD_INS_AT, 32'hA5A5_A5A5, 4'd1));
        send_item(list_cmd(CMD_INS_AT, 32'h5A5A_5A5A, 4'd3));
        send_item(list_cmd(CMD_GET, '0, 4'd1));
        send_item(list_cmd(CMD_SET, 32'h1234_5678, 4'd3));
        send_item(list_cmd(CMD_SEARCH, 32'hFFFF_FFFF, '0));
        send_item(list_cmd(CMD_SEARCH, 32'h8765_4321, '0));
        send_item(list_cmd(CMD_GET, '0, 4'd4));
        send_item(list_cmd(CMD_DEL_AT, '0, 4'd1));
        send_item(list_cmd(CMD_DEL_LAST, '0, '0));
        send_item(list_cmd(CMD_DEL_FIRST, '0, '0));
    endtask

    task automatic test_full_list;
        while (shadow_len < LIST_DEPTH) send_item(list_cmd(CMD_INS_LAST, $urandom, '0));
        send_item(list_cmd(CMD_INS_FIRST, '1, '0));
        send_item(list_cmd(CMD_INS_AT, '1, 4'd15));
        send_item(list_cmd(CMD_INS_LAST, '1, '0));
        send_item(list_cmd(CMD_GET, '0, 4'd15));
        send_item(list_cmd(CMD_SET, '1, 4'd15));
        send_item(list_cmd(CMD_SEARCH, '1, '0));
        send_item(list_cmd(CMD_DEL_AT, '0, 4'd15));
        send_item(list_cmd(CMD_DEL_AT, '0, 4'd15));
        send_item(list_cmd(CMD_CLEAR, '0, '0));
    endtask

    task automatic test_output_hold;
        int n;
        hold_out_req = 1'b1;
        for (n = 0; n < 16; n++) send_item(random_list_cmd(60));
    endtask

    task automatic test_random_mix(int n_items, int ins_pct);
        int n;
        for (n = 0; n < n_items; n++) send_item(random_list_cmd(ins_pct));
    endtask

    initial begin
        int round;
        int settle;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_index_ops();
        test_full_list();
        test_output_hold();
        for (round = 0; round < 5; round++) begin
            idle_on = (round != 2);
            test_random_mix(130, 60);
            test_random_mix(130, 20);
        end
        idle_on = 1'b0;
        test_random_mix(100, 40);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        for (settle = 0; settle < 8; settle++) @(posedge i_clk);

        $display("covered %0d commands and %0d results", items_sent, results_checked);
        $display("rejections seen: %0d full, %0d empty, %0d bad index",
                 status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_BADIDX]);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/pale_pkg.sv
rtl/pale_cell.sv
rtl/packed_array_list_engine_unit.sv
verif/packed_array_list_engine_unit_tb.sv
